### rtl/nearest_obstacle_repulse_vector_unit_defines.svh
// Assertion macros used by the checker file.
`ifndef NEAREST_OBSTACLE_REPULSE_VECTOR_UNIT_DEFINES_SVH
`define NEAREST_OBSTACLE_REPULSE_VECTOR_UNIT_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define NORV_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define NORV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### rtl/norv_pkg.sv
// ----------------------------------------------------------------------------
// norv_pkg
// Shared constants, types and tables of the nearest obstacle repulse unit.
// ----------------------------------------------------------------------------
`default_nettype none
package norv_pkg;
	localparam int CordicSteps = 16;
	localparam int TableLen = 24;
	localparam int StepW = $clog2(CordicSteps + 1);
	localparam int DivSteps = 24;
	localparam int DivCntW = $clog2(DivSteps + 1);
	localparam int CordicW = 36;
	localparam logic [15:0] MinDiv = 16'd200;
	localparam logic [29:0] GainComp = 30'd652032874;
	localparam logic signed [17:0] OutMax = 18'sd131071;
	localparam logic signed [17:0] OutMin = -18'sd131072;

	localparam logic [2:0] REG_ANGLE_START = 3'd0;
	localparam logic [2:0] REG_ANGLE_STEP = 3'd1;
	localparam logic [2:0] REG_THRESHOLD = 3'd2;
	localparam logic [2:0] REG_FLOOR = 3'd3;
	localparam logic [2:0] REG_GAIN = 3'd4;

	typedef struct packed {
		logic start_div;
		logic div_step;
		logic start_cordic;
		logic cordic_step;
		logic finish;
	} norv_cmd_t;

	typedef struct packed {
		logic div_done;
		logic cordic_done;
	} norv_stat_t;

	function automatic logic [31:0] atan_entry(input logic [4:0] i);
		case (i)
			5'd0: atan_entry = 32'h20000000;
			5'd1: atan_entry = 32'h12E4051E;
			5'd2: atan_entry = 32'h09FB385B;
			5'd3: atan_entry = 32'h051111D4;
			5'd4: atan_entry = 32'h028B0D43;
			5'd5: atan_entry = 32'h0145D7E1;
			5'd6: atan_entry = 32'h00A2F61E;
			5'd7: atan_entry = 32'h00517C55;
			5'd8: atan_entry = 32'h0028BE53;
			5'd9: atan_entry = 32'h00145F2F;
			5'd10: atan_entry = 32'h000A2F98;
			5'd11: atan_entry = 32'h000517CC;
			5'd12: atan_entry = 32'h00028BE6;
			5'd13: atan_entry = 32'h000145F3;
			5'd14: atan_entry = 32'h0000A2FA;
			5'd15: atan_entry = 32'h0000517D;
			5'd16: atan_entry = 32'h000028BE;
			5'd17: atan_entry = 32'h0000145F;
			5'd18: atan_entry = 32'h00000A30;
			5'd19: atan_entry = 32'h00000518;
			5'd20: atan_entry = 32'h0000028C;
			5'd21: atan_entry = 32'h00000146;
			5'd22: atan_entry = 32'h000000A3;
			5'd23: atan_entry = 32'h00000051;
			default: atan_entry = 32'h0;
		endcase
	endfunction
endpackage
`default_nettype wire

### rtl/norv_ctrl.sv
// ----------------------------------------------------------------------------
// norv_ctrl
// Sequencer for the end-of-scan division and CORDIC rotation.
// ----------------------------------------------------------------------------
`default_nettype none
module norv_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               go,
	input  wire logic               need_vec,
	input  wire logic               out_free,
	input  wire norv_pkg::norv_stat_t stat,
	output norv_pkg::norv_cmd_t     cmd,
	output logic                    busy
);
	import norv_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV = 2'd1;
	localparam logic [1:0] ST_ROT = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0] state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (go) state_q <= need_vec ? ST_DIV : ST_DONE;
				ST_DIV: if (stat.div_done) state_q <= ST_ROT;
				ST_ROT: if (stat.cordic_done) state_q <= ST_DONE;
				ST_DONE: if (out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		cmd.start_div = (state_q == ST_IDLE) && go && need_vec;
		cmd.div_step = (state_q == ST_DIV) && !stat.div_done;
		cmd.start_cordic = (state_q == ST_DIV) && stat.div_done;
		cmd.cordic_step = (state_q == ST_ROT) && !stat.cordic_done;
		cmd.finish = (state_q == ST_DONE) && out_free;
	end

	assign busy = (state_q != ST_IDLE);
endmodule
`default_nettype wire

### rtl/norv_dp.sv
// ----------------------------------------------------------------------------
// norv_dp
// Datapath: restoring divider and shared CORDIC rotation stage.
// ----------------------------------------------------------------------------
`default_nettype none
module norv_dp (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire norv_pkg::norv_cmd_t cmd,
	input  wire logic [23:0]         gain,
	input  wire logic [15:0]         range,
	input  wire logic [15:0]         angle,
	input  wire logic                vec_en,
	output norv_pkg::norv_stat_t     stat,
	output logic signed [17:0]       roll,
	output logic signed [17:0]       pitch
);
	import norv_pkg::*;

	logic [23:0] quot_q;
	logic [16:0] rem_q;
	logic [15:0] div_q;
	logic [DivCntW-1:0] dcnt_q;
	logic signed [CordicW-1:0] x_q, y_q;
	logic signed [33:0] z_q;
	logic flip_q;
	logic [StepW-1:0] ccnt_q;
	logic [16:0] rem_sh;
	logic [17:0] rem_try;
	logic [53:0] prod;
	logic signed [33:0] z_init;
	logic signed [CordicW-1:0] dx, dy, xr, yr;
	logic signed [CordicW-1:0] xn, yn;
	logic signed [17:0] xs, ys;
	logic [4:0] cidx;

	assign rem_sh = {rem_q[15:0], quot_q[23]};
	assign rem_try = {1'b0, rem_sh} - {2'b0, div_q};
	assign prod = {30'd0, quot_q} * {24'd0, GainComp};
	assign z_init = {{2{angle[15]}}, angle, 16'd0};
	assign cidx = 5'(ccnt_q);
	assign dx = y_q >>> ccnt_q;
	assign dy = x_q >>> ccnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
			ccnt_q <= '0;
		end else begin
			if (cmd.start_div) dcnt_q <= DivCntW'(DivSteps);
			else if (cmd.div_step) dcnt_q <= dcnt_q - 1'b1;
			if (cmd.start_cordic) ccnt_q <= '0;
			else if (cmd.cordic_step) ccnt_q <= ccnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_div) begin
			quot_q <= gain;
			rem_q <= '0;
			div_q <= (range < MinDiv) ? MinDiv : range;
		end else if (cmd.div_step) begin
			if (!rem_try[17]) begin
				rem_q <= rem_try[16:0];
				quot_q <= {quot_q[22:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quot_q <= {quot_q[22:0], 1'b0};
			end
		end
		if (cmd.start_cordic) begin
			x_q <= CordicW'((prod + 54'd32768) >> 16);
			y_q <= '0;
			if (z_init >= 34'sh40000000 || z_init < -34'sh40000000) begin
				z_q <= (z_init < 0) ? z_init + 34'sh80000000 : z_init - 34'sh80000000;
				flip_q <= 1'b1;
			end else begin
				z_q <= z_init;
				flip_q <= 1'b0;
			end
		end else if (cmd.cordic_step) begin
			if (!z_q[33]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - $signed({2'b0, atan_entry(cidx)});
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + $signed({2'b0, atan_entry(cidx)});
			end
		end
	end

	assign stat.div_done = (dcnt_q == '0);
	assign stat.cordic_done = (32'(ccnt_q) >= CordicSteps) || (32'(ccnt_q) >= TableLen);

	assign xr = (x_q + CordicW'(8192)) >>> 14;
	assign yr = (y_q + CordicW'(8192)) >>> 14;
	assign xn = flip_q ? -xr : xr;
	assign yn = flip_q ? -yr : yr;
	assign xs = (xn > CordicW'(OutMax)) ? OutMax : (xn < CordicW'(OutMin)) ? OutMin : xn[17:0];
	assign ys = (yn > CordicW'(OutMax)) ? OutMax : (yn < CordicW'(OutMin)) ? OutMin : yn[17:0];
	assign pitch = vec_en ? xs : '0;
	assign roll = vec_en ? ys : '0;
endmodule
`default_nettype wire

### rtl/nearest_obstacle_repulse_vector_unit.sv
// ----------------------------------------------------------------------------
// nearest_obstacle_repulse_vector_unit
// Nearest-beam search over a laser scan with a potential-field repulsion.
// ----------------------------------------------------------------------------
// Beams enter on the input channel (in_valid/in_stall), one item per cycle
// while in_stall is low, each a range in millimeters and a last-beam flag.
// The block keeps the nearest range strictly above the floor and the angle
// of that beam. On the last beam one result item leaves on the output
// channel (out_valid/out_stall). When avoiding, a restoring divider
// computes the magnitude and a shared CORDIC stage then rotates it; without
// avoidance the result skips both. While a scan result is being computed
// the input is stalled, so throughput is one beam per cycle inside a scan
// plus the end-of-scan computation. A result waits in the output register
// while the receiver stalls, and the block holds new beams off until it is
// taken. Reset clears the scan state and loads the register defaults.
// Configuration writes use cfg_valid/cfg_ready with an index.
// ----------------------------------------------------------------------------
`default_nettype none
module nearest_obstacle_repulse_vector_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [15:0]        range_mm,
	input  wire logic               last_beam,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [17:0]      roll_out,
	output logic signed [17:0]      pitch_out,
	output logic [15:0]             nearest_range,
	output logic signed [15:0]      nearest_angle,
	output logic                    avoiding,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [23:0]        cfg_data
);
	import norv_pkg::*;

	logic [15:0] start_q, thr_q, floor_q;
	logic [11:0] step_q;
	logic [23:0] gain_q;
	logic [15:0] best_q, bang_q, beam_q;
	logic found_q, in_scan_q, go_q;
	logic [15:0] res_range_q, res_angle_q;
	logic res_avoid_q;
	logic out_valid_q;
	logic signed [17:0] roll_q, pitch_q;
	logic take, cfg_wr, busy, better, fin_avoid;
	logic signed [17:0] roll_w, pitch_w;
	norv_cmd_t cmd;
	norv_stat_t stat;

	assign in_stall = busy || go_q || out_valid_q;
	assign take = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign cfg_wr = cfg_valid && cfg_ready;
	assign better = (range_mm > floor_q) && (range_mm < best_q);
	assign fin_avoid = found_q && (best_q < thr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 16'h8000;
			step_q <= 12'd91;
			thr_q <= 16'd2000;
			floor_q <= 16'd100;
			gain_q <= 24'd2048000;
			best_q <= 16'hFFFF;
			bang_q <= 16'h8000;
			beam_q <= 16'h8000;
			found_q <= 1'b0;
			in_scan_q <= 1'b0;
			go_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			go_q <= 1'b0;
			if (cfg_wr) begin
				case (cfg_index)
					REG_ANGLE_START: begin
						start_q <= cfg_data[15:0];
						if (!in_scan_q) begin
							bang_q <= cfg_data[15:0];
							beam_q <= cfg_data[15:0];
						end
					end
					REG_ANGLE_STEP: step_q <= cfg_data[11:0];
					REG_THRESHOLD: thr_q <= cfg_data[15:0];
					REG_FLOOR: floor_q <= cfg_data[15:0];
					REG_GAIN: gain_q <= cfg_data;
					default: ;
				endcase
			end
			if (take) begin
				in_scan_q <= 1'b1;
				if (better) begin
					best_q <= range_mm;
					bang_q <= beam_q;
					found_q <= 1'b1;
				end
				beam_q <= beam_q + {4'd0, step_q};
				go_q <= last_beam;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
				best_q <= 16'hFFFF;
				bang_q <= start_q;
				beam_q <= start_q;
				found_q <= 1'b0;
				in_scan_q <= 1'b0;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go_q) begin
			res_range_q <= best_q;
			res_angle_q <= bang_q;
			res_avoid_q <= fin_avoid;
		end
		if (cmd.finish) begin
			roll_q <= roll_w;
			pitch_q <= pitch_w;
		end
	end

	norv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (go_q),
		.need_vec (fin_avoid),
		.out_free (!out_valid_q),
		.stat     (stat),
		.cmd      (cmd),
		.busy     (busy)
	);

	// The divider loads its divisor in the cycle after the last beam, when
	// the kept range is final but not yet copied to the result register.
	norv_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.gain   (gain_q),
		.range  (best_q),
		.angle  (res_angle_q),
		.vec_en (res_avoid_q),
		.stat   (stat),
		.roll   (roll_w),
		.pitch  (pitch_w)
	);

	assign out_valid = out_valid_q;
	assign roll_out = roll_q;
	assign pitch_out = pitch_q;
	assign nearest_range = res_range_q;
	assign nearest_angle = res_angle_q;
	assign avoiding = res_avoid_q;
endmodule
`default_nettype wire

### rtl/norv_checker.sv
// ----------------------------------------------------------------------------
// norv_checker
// Port-level assertions for the nearest obstacle repulse unit.
// ----------------------------------------------------------------------------
`default_nettype none
`include "nearest_obstacle_repulse_vector_unit_defines.svh"
module norv_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_stall,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic signed [17:0] roll_out,
	input wire logic signed [17:0] pitch_out,
	input wire logic [15:0]        nearest_range,
	input wire logic               avoiding
);
	`NORV_ASSERT_IMPL(a_quiet, clk, arst_n, out_valid && !avoiding, roll_out == 0 && pitch_out == 0)
	`NORV_ASSERT_IMPL(a_avoid_range, clk, arst_n, out_valid && avoiding, nearest_range != 16'hFFFF)
	`NORV_ASSERT_IMPL(a_hold_in, clk, arst_n, out_valid, in_stall)
	`NORV_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(roll_out))
endmodule

bind nearest_obstacle_repulse_vector_unit norv_checker u_norv_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.roll_out      (roll_out),
	.pitch_out     (pitch_out),
	.nearest_range (nearest_range),
	.avoiding      (avoiding)
);
`default_nettype wire
